FILE: design/thsu_pkg.sv
`timescale 1ns / 1ps

package thsu_pkg;

  localparam int unsigned SETTLE_RESET = 100;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_START     = 5'd1,
    PH_X_FAST    = 5'd2,
    PH_X_SETTLE1 = 5'd3,
    PH_X_BACKOFF = 5'd4,
    PH_X_SETTLE2 = 5'd5,
    PH_X_SLOW    = 5'd6,
    PH_X_SETTLE3 = 5'd7,
    PH_Y_FAST    = 5'd8,
    PH_Y_SETTLE1 = 5'd9,
    PH_Y_BACKOFF = 5'd10,
    PH_Y_SETTLE2 = 5'd11,
    PH_Y_SLOW    = 5'd12,
    PH_Y_SETTLE3 = 5'd13,
    PH_Z_FAST    = 5'd14,
    PH_Z_SETTLE1 = 5'd15,
    PH_Z_BACKOFF = 5'd16,
    PH_Z_SETTLE2 = 5'd17,
    PH_Z_SLOW    = 5'd18,
    PH_Z_SETTLE3 = 5'd19,
    PH_COMPLETE  = 5'd20,
    PH_FAILED    = 5'd21
  } phase_t;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_ABORT = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [2:0] SUB_FAST     = 3'd0;
  localparam logic [2:0] SUB_BACKOFF  = 3'd2;
  localparam logic [2:0] SUB_SLOW     = 3'd4;
  localparam logic [2:0] SUB_SETTLE_C = 3'd5;

  localparam logic [2:0] REG_SETTLE  = 3'd0;
  localparam logic [2:0] REG_TIMEOUT = 3'd1;
  localparam logic [2:0] REG_BACK_XY = 3'd2;
  localparam logic [2:0] REG_BACK_Z  = 3'd3;
  localparam logic [2:0] REG_DIR_X   = 3'd4;
  localparam logic [2:0] REG_DIR_Y   = 3'd5;
  localparam logic [2:0] REG_DIR_Z   = 3'd6;

  typedef struct packed {
    logic [15:0] settle_time_ms;
    logic [31:0] state_timeout_ms;
    logic [15:0] backoff_xy_ms;
    logic [15:0] backoff_z_ms;
    logic [2:0]  home_dir;
  } cfg_t;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] hit;
    logic [2:0] skip;
  } cmd_word_t;

  typedef struct packed {
    logic       jog_active;
    logic [1:0] jog_axis;
    logic       jog_negative;
    logic       jog_slow;
    logic       stop_motion;
    logic       homed_pulse;
    logic       busy_res;
    logic       failed;
    logic [4:0] state_code;
  } res_word_t;

  // first axis from 'from' on that is not skipped
  function automatic phase_t next_axis_phase(logic [1:0] from, logic [2:0] skip);
    phase_t p;
    p = PH_COMPLETE;
    if (from <= AXIS_Z && !skip[2]) p = PH_Z_FAST;
    if (from <= AXIS_Y && !skip[1]) p = PH_Y_FAST;
    if (from == AXIS_X && !skip[0]) p = PH_X_FAST;
    return p;
  endfunction

endpackage

FILE: design/thsu_cmd_if.sv
`timescale 1ns / 1ps

interface thsu_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       endstop_x_hit;
  logic       endstop_y_hit;
  logic       endstop_z_hit;
  logic       skip_x;
  logic       skip_y;
  logic       skip_z;

  modport source (
    output valid, action, endstop_x_hit, endstop_y_hit, endstop_z_hit,
           skip_x, skip_y, skip_z,
    input  ready
  );
  modport sink (
    input  valid, action, endstop_x_hit, endstop_y_hit, endstop_z_hit,
           skip_x, skip_y, skip_z,
    output ready
  );
endinterface

FILE: design/thsu_res_if.sv
`timescale 1ns / 1ps

interface thsu_res_if;
  logic       valid;
  logic       ready;
  logic       jog_active;
  logic [1:0] jog_axis;
  logic       jog_negative;
  logic       jog_slow;
  logic       stop_motion;
  logic       homed_pulse;
  logic       busy_res;
  logic       failed;
  logic [4:0] state_code;

  modport source (
    output valid, jog_active, jog_axis, jog_negative, jog_slow, stop_motion,
           homed_pulse, busy_res, failed, state_code,
    input  ready
  );
  modport sink (
    input  valid, jog_active, jog_axis, jog_negative, jog_slow, stop_motion,
           homed_pulse, busy_res, failed, state_code,
    output ready
  );
endinterface

FILE: design/thsu_cfg_if.sv
`timescale 1ns / 1ps

interface thsu_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/thsu_regs.sv
`timescale 1ns / 1ps

module thsu_regs (
  input  logic           clk,
  input  logic           rst,
  thsu_cfg_if.sink       cfg,
  output thsu_pkg::cfg_t regs
);
  import thsu_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.settle_time_ms   <= 16'(SETTLE_RESET);
      regs.state_timeout_ms <= '0;
      regs.backoff_xy_ms    <= '0;
      regs.backoff_z_ms     <= '0;
      regs.home_dir         <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SETTLE:  regs.settle_time_ms   <= cfg.data[15:0];
        REG_TIMEOUT: regs.state_timeout_ms <= cfg.data;
        REG_BACK_XY: regs.backoff_xy_ms    <= cfg.data[15:0];
        REG_BACK_Z:  regs.backoff_z_ms     <= cfg.data[15:0];
        REG_DIR_X:   regs.home_dir[0]      <= cfg.data[0];
        REG_DIR_Y:   regs.home_dir[1]      <= cfg.data[0];
        REG_DIR_Z:   regs.home_dir[2]      <= cfg.data[0];
        default: ;
      endcase
    end
  end
endmodule

FILE: design/thsu_core.sv
`timescale 1ns / 1ps

module thsu_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  thsu_pkg::cmd_word_t cmd,
  input  thsu_pkg::cfg_t      regs,
  output thsu_pkg::res_word_t res
);
  import thsu_pkg::*;

  phase_t      phase, phase_next;
  logic [31:0] time_in_phase, time_in_phase_next;
  logic        run_active, run_active_next;

  logic [31:0] time_inc;
  logic [4:0]  rel;
  logic [1:0]  axis;
  logic [2:0]  sub;
  logic [15:0] backoff;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      time_in_phase <= '0;
      run_active    <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      time_in_phase <= time_in_phase_next;
      run_active    <= run_active_next;
    end
  end

  assign time_inc = (&time_in_phase) ? time_in_phase : time_in_phase + 32'd1;

  // axis and sub-phase of the axis phases
  always_comb begin
    rel = phase - PH_X_FAST;
    if (rel < 5'd6) begin
      axis = AXIS_X;
      sub  = rel[2:0];
    end else if (rel < 5'd12) begin
      axis = AXIS_Y;
      sub  = 3'(rel - 5'd6);
    end else begin
      axis = AXIS_Z;
      sub  = 3'(rel - 5'd12);
    end
  end

  assign backoff = (axis == AXIS_Z) ? regs.backoff_z_ms : regs.backoff_xy_ms;

  always_comb begin
    phase_next         = phase;
    time_in_phase_next = time_in_phase;
    run_active_next    = run_active;
    res                = '0;

    case (cmd.action)
      ACT_TICK: begin
        if (run_active) begin
          time_in_phase_next = time_inc;
          if (phase != PH_IDLE && phase != PH_FAILED &&
              time_inc > regs.state_timeout_ms) begin
            res.stop_motion = 1'b1;
            phase_next      = PH_FAILED;
            run_active_next = 1'b0;
          end else if (phase == PH_START) begin
            phase_next         = next_axis_phase(AXIS_X, cmd.skip);
            time_in_phase_next = '0;
          end else if (phase == PH_COMPLETE) begin
            run_active_next = 1'b0;
            res.homed_pulse = 1'b1;
            phase_next      = PH_IDLE;
          end else if (phase >= PH_X_FAST && phase < PH_COMPLETE) begin
            case (sub)
              SUB_FAST, SUB_SLOW: begin
                res.jog_active   = 1'b1;
                res.jog_axis     = axis;
                res.jog_negative = regs.home_dir[axis];
                res.jog_slow     = (sub == SUB_SLOW);
                if (cmd.hit[axis]) begin
                  res.stop_motion    = 1'b1;
                  phase_next         = phase_t'(phase + 5'd1);
                  time_in_phase_next = '0;
                end
              end
              SUB_BACKOFF: begin
                res.jog_active   = 1'b1;
                res.jog_axis     = axis;
                res.jog_negative = ~regs.home_dir[axis];
                res.jog_slow     = 1'b1;
                if (time_inc >= {16'd0, backoff}) begin
                  res.stop_motion    = 1'b1;
                  phase_next         = phase_t'(phase + 5'd1);
                  time_in_phase_next = '0;
                end
              end
              SUB_SETTLE_C: begin
                if (time_inc >= {16'd0, regs.settle_time_ms}) begin
                  phase_next         = next_axis_phase(axis + 2'd1, cmd.skip);
                  time_in_phase_next = '0;
                end
              end
              default: begin
                if (time_inc >= {16'd0, regs.settle_time_ms}) begin
                  phase_next         = phase_t'(phase + 5'd1);
                  time_in_phase_next = '0;
                end
              end
            endcase
          end
        end
      end
      ACT_START: begin
        if (!run_active) begin
          phase_next         = PH_START;
          time_in_phase_next = '0;
          run_active_next    = 1'b1;
        end
      end
      ACT_ABORT: begin
        if (run_active) begin
          res.stop_motion = 1'b1;
          phase_next      = PH_FAILED;
          run_active_next = 1'b0;
        end
      end
      default: ;
    endcase

    res.busy_res   = run_active_next;
    res.failed     = (phase_next == PH_FAILED);
    res.state_code = phase_next;
  end
endmodule

FILE: design/three_axis_homing_sequencer_unit.sv
`timescale 1ns / 1ps

// Three-axis homing sequencer.
// cmd: one word per tick (action 0), start (1) or abort (2), with endstop
//   levels and skip flags sampled when that word is accepted.
// res: exactly one status word per cmd word, in order: jog command, stop
//   pulse, homed pulse, busy, failed and the phase code after the word.
// cfg: register writes (index, data), always ready; write only while no cmd
//   word is in flight.
// Path: a cmd word is held in an input register, evaluated against the
//   phase/timer state when it advances and presented from the result
//   register, which loads together with the phase/timer state.
// Throughput: one word per cycle while res does not stall; the state update
//   is a single step of compares and a saturating 32-bit timer increment.
// When res stalls, the result register holds and the input register fills,
//   so cmd takes one more word, then ready drops until res moves.
// Reset: phase idle, timer cleared, no run, both registers empty, config
//   registers at their defaults (settle time 100).
module three_axis_homing_sequencer_unit (
  input logic      clk,
  input logic      rst,
  thsu_cmd_if.sink   cmd,
  thsu_res_if.source res,
  thsu_cfg_if.sink   cfg
);
  import thsu_pkg::*;

  cfg_t      regs;
  cmd_word_t in_word;
  logic      in_valid;
  res_word_t res_next;
  res_word_t out_word;
  logic      out_valid;
  logic      advance;

  thsu_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  thsu_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .cmd  (in_word),
    .regs (regs),
    .res  (res_next)
  );

  assign advance   = in_valid && (!out_valid || res.ready);
  assign cmd.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_word.action <= cmd.action;
      in_word.hit    <= {cmd.endstop_z_hit, cmd.endstop_y_hit, cmd.endstop_x_hit};
      in_word.skip   <= {cmd.skip_z, cmd.skip_y, cmd.skip_x};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= res_next;
    end
  end

  assign res.valid        = out_valid;
  assign res.jog_active   = out_word.jog_active;
  assign res.jog_axis     = out_word.jog_axis;
  assign res.jog_negative = out_word.jog_negative;
  assign res.jog_slow     = out_word.jog_slow;
  assign res.stop_motion  = out_word.stop_motion;
  assign res.homed_pulse  = out_word.homed_pulse;
  assign res.busy_res     = out_word.busy_res;
  assign res.failed       = out_word.failed;
  assign res.state_code   = out_word.state_code;
endmodule

FILE: test/tb_three_axis_homing_sequencer_unit.sv
`timescale 1ns / 1ps

module tb_three_axis_homing_sequencer_unit;
  import thsu_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic [2:0] REG_NONE = 3'd7;
  localparam int PHASES_PER_AXIS = 6;
  localparam int unsigned ITEM_TARGET = 1780;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  thsu_cmd_if cmd_bus ();
  thsu_res_if res_bus ();
  thsu_cfg_if cfg_bus ();

  three_axis_homing_sequencer_unit uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_bus),
    .res(res_bus),
    .cfg(cfg_bus)
  );

  // Tracks the sequencer state and queues the status word each command word must produce.
  class homing_checker;
    cfg_t        cfg;
    phase_t      phase;
    logic [31:0] dwell;
    bit          running;
    res_word_t   pending_status[$];
    int unsigned errors, n_cmd, n_res, n_homed, n_timeout, n_abort;
    int unsigned n_jog[3];

    function new();
      cfg = '0;
      cfg.settle_time_ms = 16'(SETTLE_RESET);
      phase = PH_IDLE;
      dwell = '0;
      running = 1'b0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        REG_SETTLE:  cfg.settle_time_ms = d[15:0];
        REG_TIMEOUT: cfg.state_timeout_ms = d;
        REG_BACK_XY: cfg.backoff_xy_ms = d[15:0];
        REG_BACK_Z:  cfg.backoff_z_ms = d[15:0];
        REG_DIR_X:   cfg.home_dir[0] = d[0];
        REG_DIR_Y:   cfg.home_dir[1] = d[0];
        REG_DIR_Z:   cfg.home_dir[2] = d[0];
        default: ;
      endcase
    endfunction

    function void enter(phase_t p);
      phase = p;
      dwell = '0;
    endfunction

    function phase_t first_axis(int from, logic [2:0] skip);
      for (int a = from; a < 3; a++)
        if (!skip[a]) return phase_t'(PH_X_FAST + PHASES_PER_AXIS * a);
      return PH_COMPLETE;
    endfunction

    function void sequence_tick(cmd_word_t w, inout res_word_t r);
      logic [4:0]  ofs;
      int          ax;
      logic [2:0]  sub;
      logic [15:0] lim;
      if (phase == PH_START) begin
        enter(first_axis(0, w.skip));
        return;
      end
      if (phase == PH_COMPLETE) begin
        running = 1'b0;
        r.homed_pulse = 1'b1;
        phase = PH_IDLE;
        n_homed++;
        return;
      end
      if (phase < PH_X_FAST || phase > PH_Z_SETTLE3) return;
      ofs = phase - PH_X_FAST;
      ax = ofs / PHASES_PER_AXIS;
      sub = 3'(ofs % PHASES_PER_AXIS);
      lim = (ax == AXIS_Z) ? cfg.backoff_z_ms : cfg.backoff_xy_ms;
      case (sub)
        SUB_FAST, SUB_SLOW: begin
          r.jog_active = 1'b1;
          r.jog_axis = 2'(ax);
          r.jog_negative = cfg.home_dir[ax];
          r.jog_slow = (sub == SUB_SLOW);
          n_jog[ax]++;
          if (w.hit[ax]) begin
            r.stop_motion = 1'b1;
            enter(phase_t'(phase + 1));
          end
        end
        SUB_BACKOFF: begin
          r.jog_active = 1'b1;
          r.jog_axis = 2'(ax);
          r.jog_negative = ~cfg.home_dir[ax];
          r.jog_slow = 1'b1;
          n_jog[ax]++;
          if (dwell >= lim) begin
            r.stop_motion = 1'b1;
            enter(phase_t'(phase + 1));
          end
        end
        SUB_SETTLE_C: begin
          if (dwell >= cfg.settle_time_ms) enter(first_axis(ax + 1, w.skip));
        end
        default: begin
          if (dwell >= cfg.settle_time_ms) enter(phase_t'(phase + 1));
        end
      endcase
    endfunction

    function res_word_t homing_next(cmd_word_t w);
      res_word_t r;
      r = '0;
      case (w.action)
        ACT_TICK: begin
          if (running) begin
            if (dwell != 32'hFFFF_FFFF) dwell++;
            if (phase != PH_IDLE && phase != PH_FAILED && dwell > cfg.state_timeout_ms) begin
              r.stop_motion = 1'b1;
              phase = PH_FAILED;
              running = 1'b0;
              n_timeout++;
            end else begin
              sequence_tick(w, r);
            end
          end
        end
        ACT_START: begin
          if (!running) begin
            enter(PH_START);
            running = 1'b1;
          end
        end
        ACT_ABORT: begin
          if (running) begin
            r.stop_motion = 1'b1;
            phase = PH_FAILED;
            running = 1'b0;
            n_abort++;
          end
        end
        default: ;
      endcase
      r.busy_res = running;
      r.failed = (phase == PH_FAILED);
      r.state_code = phase;
      return r;
    endfunction

    function void note_cmd(cmd_word_t w);
      n_cmd++;
      pending_status.push_back(homing_next(w));
    endfunction

    function void cmp(string f, logic [4:0] want, logic [4:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, f, want, got);
      end
    endfunction

    function void check_status(res_word_t got);
      res_word_t want;
      n_res++;
      if (pending_status.size() == 0) begin
        errors++;
        $display("%0t: status word %h with nothing outstanding", $time, got);
        return;
      end
      want = pending_status.pop_front();
      cmp("jog_active", want.jog_active, got.jog_active);
      cmp("jog_axis", want.jog_axis, got.jog_axis);
      cmp("jog_negative", want.jog_negative, got.jog_negative);
      cmp("jog_slow", want.jog_slow, got.jog_slow);
      cmp("stop_motion", want.stop_motion, got.stop_motion);
      cmp("homed_pulse", want.homed_pulse, got.homed_pulse);
      cmp("busy_res", want.busy_res, got.busy_res);
      cmp("failed", want.failed, got.failed);
      cmp("state_code", want.state_code, got.state_code);
    endfunction
  endclass

  homing_checker sb = new();
  bit tx_gaps = 1'b1;
  bit rx_steady = 1'b0;
  bit hold_res = 1'b0;
  int unsigned n_settings = 0;
  int unsigned cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("three_axis_homing_sequencer_unit regression: fail");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
      sb.check_status({res_bus.jog_active, res_bus.jog_axis, res_bus.jog_negative,
                       res_bus.jog_slow, res_bus.stop_motion, res_bus.homed_pulse,
                       res_bus.busy_res, res_bus.failed, res_bus.state_code});

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic cmd_word_t mk(logic [1:0] act, logic [2:0] hit, logic [2:0] skip);
    cmd_word_t w;
    w.action = act;
    w.hit = hit;
    w.skip = skip;
    return w;
  endfunction

  function automatic logic [2:0] sparse3();
    return 3'($urandom_range(0, 7) & $urandom_range(0, 7));
  endfunction

  // endstop of the axis being approached trips about a third of the time
  function automatic cmd_word_t tick_word();
    cmd_word_t  w;
    logic [4:0] ofs;
    int         ax;
    w = mk(ACT_TICK, sparse3(), sparse3());
    if (sb.phase >= PH_X_FAST && sb.phase <= PH_Z_SETTLE3) begin
      ofs = sb.phase - PH_X_FAST;
      ax = ofs / PHASES_PER_AXIS;
      if (ofs % PHASES_PER_AXIS == SUB_FAST || ofs % PHASES_PER_AXIS == SUB_SLOW)
        w.hit[ax] = ($urandom_range(0, 99) < 35);
    end
    return w;
  endfunction

  function automatic cfg_t random_setting();
    cfg_t        c;
    int unsigned r;
    r = $urandom_range(0, 9);
    c.settle_time_ms = (r == 0) ? 16'hFFFF : (r == 1) ? 16'd0 : 16'($urandom_range(1, 3));
    c.backoff_xy_ms = ($urandom_range(0, 11) == 0) ? 16'hFFFF : 16'($urandom_range(0, 4));
    c.backoff_z_ms = ($urandom_range(0, 11) == 0) ? 16'hFFFF : 16'($urandom_range(0, 4));
    r = $urandom_range(0, 19);
    if (r == 0) c.state_timeout_ms = 32'd0;
    else if (r == 1) c.state_timeout_ms = 32'd1;
    else if (r < 4) c.state_timeout_ms = $urandom;
    else if (r < 10) c.state_timeout_ms = 32'hFFFF_FFFF;
    else c.state_timeout_ms = $urandom_range(2, 40);
    c.home_dir = 3'($urandom_range(0, 7));
    return c;
  endfunction

  task automatic put_cmd(cmd_word_t w);
    int unsigned n;
    n = tx_gaps ? gap_len() : 0;
    if (n != 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.action <= w.action;
    cmd_bus.endstop_x_hit <= w.hit[0];
    cmd_bus.endstop_y_hit <= w.hit[1];
    cmd_bus.endstop_z_hit <= w.hit[2];
    cmd_bus.skip_x <= w.skip[0];
    cmd_bus.skip_y <= w.skip[1];
    cmd_bus.skip_z <= w.skip[2];
    @(posedge clk);
    while (cmd_bus.ready !== 1'b1) @(posedge clk);
    sb.note_cmd(w);
  endtask

  task automatic drain();
    cmd_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= d;
    @(posedge clk);
    while (cfg_bus.ready !== 1'b1) @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  // stop any run, bring the phase back to idle where the timeout allows, then program
  task automatic apply_setting(cfg_t c);
    drain();
    if (sb.running) put_cmd(mk(ACT_ABORT, sparse3(), sparse3()));
    if (sb.cfg.state_timeout_ms != 0) begin
      put_cmd(mk(ACT_START, sparse3(), 3'b111));
      put_cmd(mk(ACT_TICK, sparse3(), 3'b111));
      put_cmd(mk(ACT_TICK, sparse3(), 3'b111));
    end
    drain();
    write_reg(REG_SETTLE, {16'($urandom), c.settle_time_ms});
    write_reg(REG_TIMEOUT, c.state_timeout_ms);
    write_reg(REG_BACK_XY, {16'($urandom), c.backoff_xy_ms});
    write_reg(REG_BACK_Z, {16'($urandom), c.backoff_z_ms});
    write_reg(REG_DIR_X, {31'($urandom), c.home_dir[0]});
    write_reg(REG_DIR_Y, {31'($urandom), c.home_dir[1]});
    write_reg(REG_DIR_Z, {31'($urandom), c.home_dir[2]});
    write_reg(REG_NONE, $urandom);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  task automatic home_run();
    int unsigned budget;
    int unsigned r;
    put_cmd(mk(ACT_START, sparse3(), sparse3()));
    budget = $urandom_range(20, 140);
    while (sb.running && budget != 0) begin
      budget--;
      r = $urandom_range(0, 99);
      if (r < 2) put_cmd(mk(ACT_ABORT, sparse3(), sparse3()));
      else if (r < 4) put_cmd(mk(ACT_START, sparse3(), sparse3()));
      else if (r < 6) put_cmd(mk(ACT_NONE, sparse3(), sparse3()));
      else put_cmd(tick_word());
    end
    repeat ($urandom_range(0, 2)) put_cmd(tick_word());
  endtask

  initial begin : rx
    int unsigned n;
    res_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_res) begin
        res_bus.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_res = 1'b0;
      end else if (rx_steady) begin
        res_bus.ready <= 1'b1;
        @(posedge clk);
      end else begin
        n = gap_len();
        if (n != 0) begin
          res_bus.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        res_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin : tx
    cfg_t        c;
    int unsigned p;
    int unsigned mode;
    int unsigned first;
    int unsigned waited;
    cmd_bus.valid <= 1'b0;
    cmd_bus.action <= ACT_TICK;
    cmd_bus.endstop_x_hit <= 1'b0;
    cmd_bus.endstop_y_hit <= 1'b0;
    cmd_bus.endstop_z_hit <= 1'b0;
    cmd_bus.skip_x <= 1'b0;
    cmd_bus.skip_y <= 1'b0;
    cmd_bus.skip_z <= 1'b0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= REG_SETTLE;
    cfg_bus.data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // defaults: zero timeout fails a run on its first tick
    put_cmd(mk(ACT_TICK, 3'b111, 3'b111));
    put_cmd(mk(ACT_ABORT, 3'b000, 3'b000));
    put_cmd(mk(ACT_NONE, 3'b101, 3'b010));
    put_cmd(mk(ACT_START, 3'b000, 3'b000));
    put_cmd(mk(ACT_START, 3'b111, 3'b111));
    put_cmd(mk(ACT_TICK, 3'b000, 3'b000));
    put_cmd(mk(ACT_START, 3'b010, 3'b101));
    put_cmd(mk(ACT_ABORT, 3'b000, 3'b000));

    // full run with X skipped, zero settle, max timeout
    c.settle_time_ms = 16'd0;
    c.state_timeout_ms = 32'hFFFF_FFFF;
    c.backoff_xy_ms = 16'd0;
    c.backoff_z_ms = 16'd1;
    c.home_dir = 3'b101;
    apply_setting(c);
    put_cmd(mk(ACT_START, 3'b000, 3'b000));
    put_cmd(mk(ACT_TICK, 3'b000, 3'b001));
    put_cmd(mk(ACT_TICK, 3'b101, 3'b000));
    put_cmd(mk(ACT_TICK, 3'b010, 3'b000));
    put_cmd(mk(ACT_TICK, 3'b000, 3'b000));
    put_cmd(mk(ACT_TICK, 3'b000, 3'b000));
    put_cmd(mk(ACT_TICK, 3'b000, 3'b000));
    put_cmd(mk(ACT_TICK, 3'b010, 3'b000));
    put_cmd(mk(ACT_TICK, 3'b000, 3'b000));
    put_cmd(mk(ACT_TICK, 3'b100, 3'b000));
    put_cmd(mk(ACT_TICK, 3'b000, 3'b000));
    put_cmd(mk(ACT_TICK, 3'b000, 3'b000));
    put_cmd(mk(ACT_TICK, 3'b000, 3'b000));
    put_cmd(mk(ACT_TICK, 3'b100, 3'b000));
    put_cmd(mk(ACT_TICK, 3'b000, 3'b000));
    put_cmd(mk(ACT_TICK, 3'b000, 3'b000));
    put_cmd(mk(ACT_NONE, 3'b111, 3'b111));

    for (p = 0; sb.n_cmd < ITEM_TARGET; p++) begin
      if (p == 0) begin
        c.settle_time_ms = 16'd0;
        c.state_timeout_ms = 32'hFFFF_FFFF;
        c.backoff_xy_ms = 16'd0;
        c.backoff_z_ms = 16'd0;
        c.home_dir = 3'b000;
      end else if (p == 1) begin
        c.settle_time_ms = 16'hFFFF;
        c.state_timeout_ms = 32'd50;
        c.backoff_xy_ms = 16'hFFFF;
        c.backoff_z_ms = 16'hFFFF;
        c.home_dir = 3'b111;
      end else begin
        c = random_setting();
      end
      apply_setting(c);
      mode = (p < 4) ? p : $urandom_range(0, 3);
      tx_gaps = mode[0];
      rx_steady = !mode[1];
      if (p == 3) begin
        // receiver stalls long while words keep coming
        tx_gaps = 1'b0;
        hold_res = 1'b1;
      end
      first = sb.n_cmd;
      while (sb.n_cmd - first < PHASE_ITEMS && sb.n_cmd < ITEM_TARGET) begin
        home_run();
        if (p == 5) drain();
      end
    end

    cmd_bus.valid <= 1'b0;
    waited = 0;
    while (sb.pending_status.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (sb.pending_status.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d status words never arrived", $time, sb.pending_status.size());
    end
    $display("Covered %0d command words, %0d status words, %0d register settings.",
             sb.n_cmd, sb.n_res, n_settings);
    $display("Runs homed %0d, timed out %0d, aborted %0d; jog words X %0d Y %0d Z %0d.",
             sb.n_homed, sb.n_timeout, sb.n_abort, sb.n_jog[0], sb.n_jog[1], sb.n_jog[2]);
    if (sb.errors == 0) begin
      $display("three_axis_homing_sequencer_unit regression: pass");
    end else begin
      $display("three_axis_homing_sequencer_unit regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
design/thsu_pkg.sv
design/thsu_cmd_if.sv
design/thsu_res_if.sv
design/thsu_cfg_if.sv
design/thsu_regs.sv
design/thsu_core.sv
design/three_axis_homing_sequencer_unit.sv
test/tb_three_axis_homing_sequencer_unit.sv
